/* rtl/sts_pkg.sv */
// sts_pkg: shared types and constants of the sorted table binary search block
// payload structs for both channels, request codes, default parameter values
// no dependencies

package sts_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 256;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // widths of the channel fields
  localparam int unsigned INDEX_WIDTH = 8;
  localparam int unsigned KEY_WIDTH   = 32;

  typedef enum logic {
    REQ_WRITE  = 1'b0,
    REQ_SEARCH = 1'b1
  } req_type_e;

  typedef struct packed {
    req_type_e                     req_type;
    logic [INDEX_WIDTH-1:0]        write_index;
    logic signed [KEY_WIDTH-1:0]   item_value;
    logic [INDEX_WIDTH-1:0]        low_index;
    logic [INDEX_WIDTH-1:0]        high_index;
  } sts_in_t;

  typedef struct packed {
    logic                   found;
    logic [INDEX_WIDTH-1:0] position;
  } sts_out_t;

endpackage

/* rtl/sts_ram.sv */
// sts_ram: generic single-write, single-read synchronous ram
// registered read data, updated only on a read enable
// no dependencies

module sts_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/sts_engine.sv */
// sts_engine: binary search sequencer, one table probe per cycle
// keeps the bounds, issues ram reads, compares and holds a stalled result
// depends on sts_pkg

module sts_engine #(
  parameter int unsigned TABLE_DEPTH = sts_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = sts_pkg::VALUE_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [VALUE_WIDTH-1:0]         key_i,
  input  logic [sts_pkg::INDEX_WIDTH-1:0] low_i,
  input  logic [sts_pkg::INDEX_WIDTH-1:0] high_i,
  output logic                           idle_o,
  output logic                           rd_en_o,
  output logic [$clog2(TABLE_DEPTH)-1:0] rd_addr_o,
  input  logic [VALUE_WIDTH-1:0]         rd_data_i,
  output logic                           res_valid_o,
  output sts_pkg::sts_out_t              res_o,
  input  logic                           res_ready_i
);

  import sts_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned IW = (AW > INDEX_WIDTH) ? AW : INDEX_WIDTH;
  // one bit for mid + 1 beyond the table, one sign bit for mid - 1 below zero
  localparam int unsigned BW = IW + 2;

  typedef logic signed [BW-1:0] bound_t;

  localparam bound_t ONE    = bound_t'(1);
  localparam bound_t HI_MAX = bound_t'(TABLE_DEPTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_PROBE = 3'b010,
    ST_HOLD  = 3'b100
  } state_e;

  state_e state_q, state_d;
  bound_t lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [VALUE_WIDTH-1:0] key_q, key_d;
  sts_out_t res_q, res_d;

  bound_t lo_in, hi_in, hi_sat, mid0;
  bound_t mid_left, mid_right;
  logic   empty0, eq, gt;
  logic   finish;
  sts_out_t res_now;

  // start of a search
  assign lo_in  = bound_t'(low_i);
  assign hi_in  = bound_t'(high_i);
  assign hi_sat = (hi_in > HI_MAX) ? HI_MAX : hi_in;
  assign empty0 = hi_sat < lo_in;
  assign mid0   = lo_in + ((hi_sat - lo_in) >>> 1);

  // both candidate next midpoints, picked by the compare
  assign mid_left  = lo_q + ((mid_q - ONE - lo_q) >>> 1);
  assign mid_right = mid_q + ONE + ((hi_q - mid_q - ONE) >>> 1);

  assign eq = $signed(rd_data_i) == $signed(key_q);
  assign gt = $signed(rd_data_i) >  $signed(key_q);

  always_comb begin
    state_d = state_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    key_d   = key_q;
    res_d   = res_q;
    rd_en_o = 1'b0;
    finish  = 1'b0;
    res_now = '0;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          key_d = key_i;
          if (empty0) begin
            finish = 1'b1;
          end else begin
            lo_d    = lo_in;
            hi_d    = hi_sat;
            mid_d   = mid0;
            rd_en_o = 1'b1;
            state_d = ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        if (eq) begin
          res_now.found    = 1'b1;
          res_now.position = mid_q[INDEX_WIDTH-1:0];
          finish           = 1'b1;
        end else if (gt) begin
          if (mid_q == lo_q) begin
            finish = 1'b1;
          end else begin
            hi_d    = mid_q - ONE;
            mid_d   = mid_left;
            rd_en_o = 1'b1;
          end
        end else begin
          if (mid_q == hi_q) begin
            finish = 1'b1;
          end else begin
            lo_d    = mid_q + ONE;
            mid_d   = mid_right;
            rd_en_o = 1'b1;
          end
        end
      end
      ST_HOLD: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // hand the result over at once, or park it until the output frees up
    if (finish) begin
      if (res_ready_i) begin
        state_d = ST_IDLE;
      end else begin
        res_d   = res_now;
        state_d = ST_HOLD;
      end
    end
  end

  assign rd_addr_o   = mid_d[AW-1:0];
  assign idle_o      = state_q == ST_IDLE;
  assign res_valid_o = finish || (state_q == ST_HOLD);
  assign res_o       = (state_q == ST_HOLD) ? res_q : res_now;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    key_q <= key_d;
    res_q <= res_d;
  end

endmodule

/* rtl/sorted_table_binary_search.sv */
// sorted table binary search: a write transfer gives no result
// a search makes one probe per ram read (at most 9 for a 256-entry range), one ram
// read per cycle; the result lands in the output register at the end of the last probe
// the next item is taken the cycle after; a stalled result waits in the engine
// reset clears the control state only; table entries are undefined until written
// depends on sts_pkg, sts_ram, sts_engine

module sorted_table_binary_search #(
  parameter int unsigned TABLE_DEPTH = sts_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = sts_pkg::VALUE_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sts_pkg::sts_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sts_pkg::sts_out_t out_data_o
);

  import sts_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned IW = (AW > INDEX_WIDTH) ? AW : INDEX_WIDTH;

  // depth in a width that holds it, for the write range check
  localparam logic [IW:0] DEPTH_W = (IW + 1)'(TABLE_DEPTH);

  logic                   in_xfer;
  logic                   eng_idle;
  logic [VALUE_WIDTH-1:0] value_adj;
  logic [IW:0]            widx_ext;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;

  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic [VALUE_WIDTH-1:0] rd_data;

  logic                   res_valid;
  logic                   res_ready;
  sts_out_t               res;

  logic                   out_valid_q, out_valid_d;
  sts_out_t               out_data_q, out_data_d;

  // items enter only while the engine is idle: no search running and no result held
  assign in_ready_o = eng_idle;
  assign in_xfer    = in_valid_i && in_ready_o;

  // the key and entries are two's complement at the table width:
  // narrower tables drop the upper bits, wider ones zero-extend
  assign value_adj = VALUE_WIDTH'($unsigned(in_data_i.item_value));

  // writes beyond the table are dropped
  assign widx_ext = (IW + 1)'(in_data_i.write_index);
  assign wr_en    = in_xfer && (in_data_i.req_type == REQ_WRITE) && (widx_ext < DEPTH_W);
  assign wr_addr  = widx_ext[AW-1:0];

  sts_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (value_adj),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  sts_engine #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_xfer && (in_data_i.req_type == REQ_SEARCH)),
    .key_i       (value_adj),
    .low_i       (in_data_i.low_index),
    .high_i      (in_data_i.high_index),
    .idle_o      (eng_idle),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // output register: takes a result whenever it is empty or being drained this cycle
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_data_d  = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* bench/sorted_table_binary_search_tb.sv */
// testbench for sorted_table_binary_search: table writes and key searches with random idling
// a shadow copy of the table predicts every search result, which is checked field by field
// depends on sts_pkg and the sorted_table_binary_search rtl

module sorted_table_binary_search_tb;
  import sts_pkg::*;

  localparam int DEPTH        = TABLE_DEPTH_DEF;
  localparam int LAST_SLOT    = DEPTH - 1;
  localparam int TIMEOUT_TIME = 2_000_000;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int SETTLE_CYCLES = 20;

  localparam logic signed [KEY_WIDTH-1:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_WIDTH-1:0] VALUE_MAX = 32'sh7fff_ffff;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  sts_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  sts_out_t out_data_o;

  // shadow of the block's table, plus which slots hold real data
  logic signed [KEY_WIDTH-1:0] entry_model [DEPTH];
  bit                          entry_written [DEPTH];

  // search results still owed by the block, oldest first
  sts_out_t awaited_lookups [$];
  sts_out_t lookup_want;

  int mismatch_count = 0;
  // idle limits for the request side and the result side
  int gap_max   = 16;
  int stall_max = 16;

  sorted_table_binary_search dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  // hard stop in case the block hangs
  initial begin
    #(TIMEOUT_TIME);
    $display("TEST FAILED");
    $finish;
  end

  // idle cycles before a transfer; zero at least a third of the time so bursts happen
  function automatic int draw_idle(input int max_cycles);
    if (max_cycles == 0 || $urandom_range(0, 2) == 0) return 0;
    return int'($urandom_range(0, max_cycles));
  endfunction

  // walk the same midpoint probes as the block over the shadow table;
  // also flags a probe that would land on a slot never written
  function automatic sts_out_t predict_lookup(input logic signed [KEY_WIDTH-1:0] key,
                                              input int first, input int last,
                                              output bit touches_unwritten);
    sts_out_t res;
    int       lo_b;
    int       hi_b;
    int       mid;
    bit       done;
    res               = '0;
    touches_unwritten = 1'b0;
    lo_b              = first;
    hi_b              = last;
    done              = 1'b0;
    if (hi_b > LAST_SLOT) hi_b = LAST_SLOT;
    // bounds are plain ints, so mid - 1 may go negative and end the walk
    while (!done && hi_b >= lo_b) begin
      mid = lo_b + (hi_b - lo_b) / 2;
      if (!entry_written[mid]) touches_unwritten = 1'b1;
      if (entry_model[mid] == key) begin
        res.found    = 1'b1;
        res.position = mid[INDEX_WIDTH-1:0];
        done         = 1'b1;
      end else if (entry_model[mid] > key) begin
        hi_b = mid - 1;
      end else begin
        lo_b = mid + 1;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input sts_out_t got, input sts_out_t want);
    mismatch_count++;
    $display("mismatch at %0t: %s: got found=%0b position=%0d, want found=%0b position=%0d",
             $time, what, got.found, got.position, want.found, want.position);
  endtask

  // one request transfer; valid stays up across back-to-back items
  task automatic send_item(input sts_in_t item);
    int gap;
    gap = draw_idle(gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_data_i  <= item;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_entry(input int slot, input logic signed [KEY_WIDTH-1:0] value);
    sts_in_t item;
    item.req_type    = REQ_WRITE;
    item.write_index = 8'(slot);
    item.item_value  = value;
    // range fields are ignored by a write, so fill them with noise
    item.low_index   = 8'($urandom);
    item.high_index  = 8'($urandom);
    send_item(item);
    entry_model[slot]   = value;
    entry_written[slot] = 1'b1;
  endtask

  task automatic search_key(input logic signed [KEY_WIDTH-1:0] key, input int first,
                            input int last);
    sts_in_t  item;
    sts_out_t expected;
    bit       unsafe;
    expected = predict_lookup(key, first, last, unsafe);
    // never probe a slot whose contents are still undefined
    if (unsafe) return;
    item.req_type    = REQ_SEARCH;
    item.write_index = 8'($urandom);
    item.item_value  = key;
    item.low_index   = 8'(first);
    item.high_index  = 8'(last);
    send_item(item);
    awaited_lookups.push_back(expected);
  endtask

  // drop valid, let every owed result come back, then let the pipeline settle
  task automatic wait_all_results();
    int guard;
    guard      = 0;
    in_valid_i <= 1'b0;
    while (awaited_lookups.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // load all slots with an ascending sequence; a small step gives long runs of equal values
  task automatic fill_sorted_table();
    int     step_max;
    longint span;
    longint level;
    step_max = 1 << $urandom_range(0, 23);
    span     = (longint'(1) << 32) - 256 * longint'(step_max);
    level    = -(longint'(1) << 31) + longint'($urandom) % span;
    for (int i = 0; i < DEPTH; i++) begin
      write_entry(i, level[KEY_WIDTH-1:0]);
      level += longint'($urandom_range(0, step_max));
    end
  endtask

  // few written slots: single-slot ranges, bounds dropping below zero, empty ranges
  task automatic test_sparse_probes();
    write_entry(0, VALUE_MIN + 1);
    write_entry(127, 0);
    write_entry(LAST_SLOT, VALUE_MAX);
    search_key(VALUE_MIN + 1, 0, 0);
    // entry above the key at slot zero pushes the upper bound to -1
    search_key(VALUE_MIN, 0, 0);
    search_key(VALUE_MAX, LAST_SLOT, LAST_SLOT);
    search_key(-1, LAST_SLOT, LAST_SLOT);
    search_key(0, 127, 127);
    search_key(1, 127, 127);
    // low above high: no probe at all
    search_key(VALUE_MAX, 200, 100);
    search_key(VALUE_MIN, LAST_SLOT, 0);
    search_key(0, 1, 0);
    wait_all_results();
  endtask

  // full sorted table with the value extremes at both ends
  task automatic test_sorted_extremes();
    fill_sorted_table();
    write_entry(0, VALUE_MIN);
    write_entry(LAST_SLOT, VALUE_MAX);
    search_key(VALUE_MIN, 0, LAST_SLOT);
    search_key(VALUE_MAX, 0, LAST_SLOT);
    search_key(entry_model[128], 0, LAST_SLOT);
    search_key(entry_model[1], 0, LAST_SLOT);
    search_key(VALUE_MIN, 1, LAST_SLOT);
    search_key(VALUE_MAX, 0, LAST_SLOT - 1);
    search_key(entry_model[77] + 1, 0, LAST_SLOT);
    wait_all_results();
  endtask

  // out-of-order entries and runs of equal values still follow the probe sequence
  task automatic test_unsorted_and_duplicates();
    logic signed [KEY_WIDTH-1:0] run_value;
    fill_sorted_table();
    // huge value at the first midpoint sends every smaller key to the left half
    write_entry(127, VALUE_MAX);
    search_key(entry_model[60], 0, LAST_SLOT);
    search_key(entry_model[200], 0, LAST_SLOT);
    search_key(VALUE_MAX, 0, LAST_SLOT);
    run_value = entry_model[63];
    for (int i = 60; i <= 66; i++) write_entry(i, run_value);
    search_key(run_value, 60, 66);
    search_key(run_value, 0, LAST_SLOT);
    search_key(run_value, 61, 62);
    repeat (6) write_entry($urandom_range(0, LAST_SLOT), $urandom);
    repeat (4) search_key(entry_model[$urandom_range(0, LAST_SLOT)], 0, LAST_SLOT);
    wait_all_results();
  endtask

  // one random request: mostly searches over a sorted table, some writes that keep
  // the order, a few that break it
  task automatic random_request();
    int                          pick;
    int                          key_pick;
    int                          slot;
    int                          first;
    int                          last;
    longint                      lower;
    longint                      upper;
    logic signed [KEY_WIDTH-1:0] key;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      slot = $urandom_range(0, LAST_SLOT);
      if (pick < 14) begin
        lower = (slot > 0) ? entry_model[slot - 1] : VALUE_MIN;
        upper = (slot < LAST_SLOT) ? entry_model[slot + 1] : VALUE_MAX;
        if (lower <= upper) begin
          write_entry(slot, 32'(lower + longint'($urandom) % (upper - lower + 1)));
        end else begin
          write_entry(slot, lower[KEY_WIDTH-1:0]);
        end
      end else begin
        write_entry(slot, $urandom);
      end
    end else begin
      if (pick < 30) begin
        first = $urandom_range(1, LAST_SLOT);
        last  = $urandom_range(0, first - 1);
      end else if (pick < 40) begin
        first = 0;
        last  = LAST_SLOT;
      end else if (pick < 60) begin
        first = $urandom_range(0, LAST_SLOT);
        last  = first + $urandom_range(0, 3);
        if (last > LAST_SLOT) last = LAST_SLOT;
      end else begin
        first = $urandom_range(0, LAST_SLOT);
        last  = $urandom_range(first, LAST_SLOT);
      end
      key_pick = $urandom_range(0, 9);
      if (first > last || key_pick < 3) begin
        key = $urandom;
      end else begin
        // key taken from inside the range, sometimes nudged off by one
        key = entry_model[$urandom_range(first, last)];
        if (key_pick == 3) key = key + 1;
        else if (key_pick == 4) key = key - 1;
      end
      search_key(key, first, last);
    end
  endtask

  task automatic test_random_traffic();
    for (int round = 0; round < 3; round++) begin
      // middle round runs with no idling on either side
      gap_max   = (round == 1) ? 0 : 16;
      stall_max = (round == 1) ? 0 : 16;
      // the table is loaded once; later rounds work on what the earlier ones left
      if (round == 0) fill_sorted_table();
      repeat (195) random_request();
      wait_all_results();
    end
    gap_max   = 16;
    stall_max = 16;
  endtask

  // result side: random stalls, then ready held until a transfer
  initial begin
    int stall;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_idle(stall_max);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // compare each result transfer with the oldest owed search
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_lookups.size() == 0) begin
        report_mismatch("result with no search pending", out_data_o, '0);
      end else begin
        lookup_want = awaited_lookups.pop_front();
        if (out_data_o.found !== lookup_want.found) begin
          report_mismatch("found flag", out_data_o, lookup_want);
        end
        if (out_data_o.position !== lookup_want.position) begin
          report_mismatch("position", out_data_o, lookup_want);
        end
      end
    end
  end

  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_sparse_probes();
    test_sorted_extremes();
    test_unsorted_and_duplicates();
    test_random_traffic();

    wait_all_results();
    // anything still owed never came back
    while (awaited_lookups.size() != 0) begin
      report_mismatch("search without result", '0, awaited_lookups.pop_front());
    end
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sorted_table_binary_search.f */
rtl/sts_pkg.sv
rtl/sts_ram.sv
rtl/sts_engine.sv
rtl/sorted_table_binary_search.sv
bench/sorted_table_binary_search_tb.sv
